// ----- sv/twg_pkg.sv -----
`default_nettype none

package twg_pkg;

  // Full-scale DAC code and gain format.
  localparam int unsigned CodeW     = 12;
  localparam int unsigned GainW     = 15;
  localparam int unsigned PeriodW   = 16;
  localparam int unsigned GainShift = 14;
  localparam int unsigned TriW      = 13;
  localparam int unsigned SineAddrW = 8;
  localparam int unsigned IndexW    = 8;

  localparam logic [CodeW-1:0] FullScale = 12'd4095;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgShape  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgGain   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgPeriod = 2'd2;

  localparam int unsigned CfgDataW = 16;

  // Waveform shape codes; the fourth code produces a flat zero output.
  localparam logic [1:0] ShapeSine     = 2'd0;
  localparam logic [1:0] ShapeTriangle = 2'd1;
  localparam logic [1:0] ShapeSquare   = 2'd2;

  localparam logic [GainW-1:0]   GainReset   = 15'd16384;
  localparam logic [PeriodW-1:0] PeriodReset = 16'd1098;

  // First quarter of the sine wave, round(2047.5 * (1 + sin(2*pi*k/256))).
  function automatic logic [CodeW-1:0] quarter_sine(input logic [6:0] k);
    logic [CodeW-1:0] v;
    v = '0;
    case (k)
      7'd0:  v = 12'd2048;  7'd1:  v = 12'd2098;  7'd2:  v = 12'd2148;
      7'd3:  v = 12'd2198;  7'd4:  v = 12'd2248;  7'd5:  v = 12'd2298;
      7'd6:  v = 12'd2348;  7'd7:  v = 12'd2398;  7'd8:  v = 12'd2447;
      7'd9:  v = 12'd2496;  7'd10: v = 12'd2545;  7'd11: v = 12'd2594;
      7'd12: v = 12'd2642;  7'd13: v = 12'd2690;  7'd14: v = 12'd2737;
      7'd15: v = 12'd2784;  7'd16: v = 12'd2831;  7'd17: v = 12'd2877;
      7'd18: v = 12'd2923;  7'd19: v = 12'd2968;  7'd20: v = 12'd3013;
      7'd21: v = 12'd3057;  7'd22: v = 12'd3100;  7'd23: v = 12'd3143;
      7'd24: v = 12'd3185;  7'd25: v = 12'd3226;  7'd26: v = 12'd3267;
      7'd27: v = 12'd3307;  7'd28: v = 12'd3346;  7'd29: v = 12'd3385;
      7'd30: v = 12'd3423;  7'd31: v = 12'd3459;  7'd32: v = 12'd3495;
      7'd33: v = 12'd3530;  7'd34: v = 12'd3565;  7'd35: v = 12'd3598;
      7'd36: v = 12'd3630;  7'd37: v = 12'd3662;  7'd38: v = 12'd3692;
      7'd39: v = 12'd3722;  7'd40: v = 12'd3750;  7'd41: v = 12'd3777;
      7'd42: v = 12'd3804;  7'd43: v = 12'd3829;  7'd44: v = 12'd3853;
      7'd45: v = 12'd3876;  7'd46: v = 12'd3898;  7'd47: v = 12'd3919;
      7'd48: v = 12'd3939;  7'd49: v = 12'd3958;  7'd50: v = 12'd3975;
      7'd51: v = 12'd3992;  7'd52: v = 12'd4007;  7'd53: v = 12'd4021;
      7'd54: v = 12'd4034;  7'd55: v = 12'd4045;  7'd56: v = 12'd4056;
      7'd57: v = 12'd4065;  7'd58: v = 12'd4073;  7'd59: v = 12'd4080;
      7'd60: v = 12'd4085;  7'd61: v = 12'd4089;  7'd62: v = 12'd4093;
      7'd63: v = 12'd4094;  7'd64: v = 12'd4095;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ----- sv/twg_base.sv -----
`default_nettype none

// Selects the unscaled sample value for the current table position.
module twg_base #(
  parameter int unsigned TABLE_DEPTH = 256,
  parameter int unsigned PW          = $clog2(TABLE_DEPTH)
) (
  input  wire logic [1:0]                        shape_i,
  input  wire logic [PW-1:0]                     pos_i,
  input  wire logic [twg_pkg::SineAddrW-1:0]     sine_addr_i,
  input  wire logic [twg_pkg::TriW-1:0]          tri_up_i,
  input  wire logic [twg_pkg::TriW-1:0]          tri_down_i,
  output logic      [twg_pkg::TriW-1:0]          base_o
);

  localparam logic [PW-1:0] Half = PW'(TABLE_DEPTH / 2);

  logic [6:0]                  quarter_k;
  logic                        sine_neg;
  logic [twg_pkg::CodeW-1:0]   quarter_v;
  logic [twg_pkg::CodeW-1:0]   sine_v;
  logic                        first_half;

  // Fold the full-wave address onto the stored quarter wave.
  always_comb begin
    sine_neg  = 1'b0;
    quarter_k = sine_addr_i[6:0];
    if (sine_addr_i <= 8'd64) begin
      quarter_k = sine_addr_i[6:0];
    end else if (sine_addr_i <= 8'd128) begin
      quarter_k = 7'(8'd128 - sine_addr_i);
    end else if (sine_addr_i < 8'd192) begin
      quarter_k = 7'(sine_addr_i - 8'd128);
      sine_neg  = 1'b1;
    end else begin
      quarter_k = 7'(8'd0 - sine_addr_i);
      sine_neg  = 1'b1;
    end
  end

  assign quarter_v  = twg_pkg::quarter_sine(quarter_k);
  assign sine_v     = sine_neg ? (twg_pkg::FullScale - quarter_v) : quarter_v;
  assign first_half = (pos_i < Half);

  // With an odd table depth the falling half of the triangle can exceed full
  // scale before the gain, so the base keeps the wider triangle width.
  always_comb begin
    case (shape_i)
      twg_pkg::ShapeSine:     base_o = twg_pkg::TriW'(sine_v);
      twg_pkg::ShapeTriangle: base_o = first_half ? tri_up_i : tri_down_i;
      twg_pkg::ShapeSquare:   base_o = first_half ? '0
                                                  : twg_pkg::TriW'(twg_pkg::FullScale);
      default:                base_o = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- sv/table_waveform_generator_top.sv -----
`default_nettype none

// Lookup-table waveform source for a 12-bit DAC.
// Input channel: each beat is one timer tick; run_i = 1 counts the tick, run_i = 0
// leaves the tick counter and the table position untouched. Every beat is
// accepted whether or not it produces a sample.
// When the tick counter has reached sample_period, the beat emits one sample on
// the output channel: dac_code_o (sine, triangle, square or flat zero base value
// scaled by the Q1.14 gain and clamped at 4095), phase_index_o (low 8 bits of
// the table position) and cycle_end_o (set on the last table entry).
// A sample passes through the lookup register, which holds the table value of
// its tick beat, and then the output register, which holds the gain-scaled code.
// Throughput: one tick beat per cycle while in_ready_o is high. Table-position
// quotients are kept as running quotient and remainder registers, so no divider
// sits in the path. If the receiver stalls, one sample waits in the output
// register and a second in the lookup register; after that in_ready_o drops
// until the receiver takes a beat.
// Configuration: cfg_ready_o is always high; index 0 selects the shape, 1 the
// gain, 2 the sample period; other indexes are ignored. Write only while idle.
// Reset clears the tick counter and position and loads sine, unity gain and a
// period of 1098.
module table_waveform_generator_top #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic                             run_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic [twg_pkg::CodeW-1:0]             dac_code_o,
  output logic [twg_pkg::IndexW-1:0]            phase_index_o,
  output logic                                  cycle_end_o,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [twg_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  wire logic [twg_pkg::CfgDataW-1:0]     cfg_data_i
);

  localparam int unsigned PW  = $clog2(TABLE_DEPTH);
  localparam int unsigned PW1 = PW + 1;
  localparam int unsigned TW  = twg_pkg::TriW;
  localparam int unsigned SW  = twg_pkg::SineAddrW;
  localparam int unsigned ProdW = twg_pkg::TriW + twg_pkg::GainW;

  localparam logic [PW1-1:0] Depth   = PW1'(TABLE_DEPTH);
  localparam logic [PW-1:0]  LastPos = PW'(TABLE_DEPTH - 1);
  // One table step advances 8190*pos/depth and 256*pos/depth by these amounts.
  localparam logic [TW-1:0]  TriQ  = TW'(8190 / TABLE_DEPTH);
  localparam logic [PW1-1:0] TriR  = PW1'(8190 % TABLE_DEPTH);
  localparam logic [SW-1:0]  SineQ = SW'(256 / TABLE_DEPTH);
  localparam logic [PW1-1:0] SineR = PW1'(256 % TABLE_DEPTH);

  // Configuration registers.
  logic [1:0]                     shape_q;
  logic [twg_pkg::GainW-1:0]      gain_q;
  logic [twg_pkg::PeriodW-1:0]    period_q;

  // Timer state and the running quotients that follow the table position.
  logic [twg_pkg::PeriodW-1:0]    tick_q, tick_d;
  logic [PW-1:0]                  pos_q, pos_d;
  logic [TW-1:0]                  up_quo_q, up_quo_d;
  logic [PW-1:0]                  up_rem_q, up_rem_d;
  logic [TW-1:0]                  dn_quo_q, dn_quo_d;
  logic [PW-1:0]                  dn_rem_q, dn_rem_d;
  logic [SW-1:0]                  sine_quo_q, sine_quo_d;
  logic [PW-1:0]                  sine_rem_q, sine_rem_d;

  // Lookup stage and output stage.
  logic                           lk_valid_q, lk_valid_d;
  logic [TW-1:0]                  lk_base_q;
  logic [twg_pkg::IndexW-1:0]     lk_index_q;
  logic                           lk_end_q;
  logic                           out_valid_q, out_valid_d;
  logic [twg_pkg::CodeW-1:0]      out_code_q;
  logic [twg_pkg::IndexW-1:0]     out_index_q;
  logic                           out_end_q;

  logic                           in_fire;
  logic                           count_tick;
  logic                           emit;
  logic                           out_load;
  logic [TW-1:0]                  base;
  logic [PW1-1:0]                 up_sum, dn_diff, sine_sum;
  logic                           up_carry, dn_borrow, sine_carry;
  logic [ProdW-1:0]               product;
  logic [ProdW-twg_pkg::GainShift-1:0] scaled;
  logic [twg_pkg::CodeW-1:0]      code;

  assign cfg_ready_o = 1'b1;

  // The output register loads a lookup sample when empty or when its beat leaves.
  assign out_load   = lk_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !lk_valid_q || out_load;
  assign in_fire    = in_valid_i && in_ready_o;
  assign count_tick = in_fire && run_i;
  assign emit       = count_tick && (tick_q >= period_q);

  // Running quotient/remainder updates for one table step.
  assign up_sum     = PW1'(up_rem_q) + TriR;
  assign up_carry   = (up_sum >= Depth);
  assign dn_borrow  = (PW1'(dn_rem_q) < TriR);
  assign dn_diff    = dn_borrow ? (PW1'(dn_rem_q) + Depth - TriR) : (PW1'(dn_rem_q) - TriR);
  assign sine_sum   = PW1'(sine_rem_q) + SineR;
  assign sine_carry = (sine_sum >= Depth);

  always_comb begin
    tick_d     = tick_q;
    pos_d      = pos_q;
    up_quo_d   = up_quo_q;
    up_rem_d   = up_rem_q;
    dn_quo_d   = dn_quo_q;
    dn_rem_d   = dn_rem_q;
    sine_quo_d = sine_quo_q;
    sine_rem_d = sine_rem_q;
    if (count_tick) begin
      if (!emit) begin
        tick_d = tick_q + 1'b1;
      end else begin
        tick_d = '0;
        if (pos_q == LastPos) begin
          // Wrap to the start of the table; every quotient restarts there.
          pos_d      = '0;
          up_quo_d   = '0;
          up_rem_d   = '0;
          dn_quo_d   = TW'(8190);
          dn_rem_d   = '0;
          sine_quo_d = '0;
          sine_rem_d = '0;
        end else begin
          pos_d      = pos_q + 1'b1;
          up_quo_d   = up_quo_q + TriQ + TW'(up_carry);
          up_rem_d   = up_carry ? PW'(up_sum - Depth) : PW'(up_sum);
          dn_quo_d   = dn_quo_q - TriQ - TW'(dn_borrow);
          dn_rem_d   = PW'(dn_diff);
          sine_quo_d = sine_quo_q + SineQ + SW'(sine_carry);
          sine_rem_d = sine_carry ? PW'(sine_sum - Depth) : PW'(sine_sum);
        end
      end
    end
  end

  twg_base #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .PW         (PW)
  ) u_base (
    .shape_i    (shape_q),
    .pos_i      (pos_q),
    .sine_addr_i(sine_quo_q),
    .tri_up_i   (up_quo_q),
    .tri_down_i (dn_quo_q),
    .base_o     (base)
  );

  always_comb begin
    lk_valid_d = lk_valid_q;
    if (emit) begin
      lk_valid_d = 1'b1;
    end else if (out_load) begin
      lk_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Gain scaling: truncate the Q1.14 product and clamp at full scale.
  assign product = ProdW'(lk_base_q) * ProdW'(gain_q);
  assign scaled  = product[ProdW-1:twg_pkg::GainShift];
  assign code    = (scaled > (ProdW-twg_pkg::GainShift)'(twg_pkg::FullScale))
                   ? twg_pkg::FullScale : scaled[twg_pkg::CodeW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shape_q     <= twg_pkg::ShapeSine;
      gain_q      <= twg_pkg::GainReset;
      period_q    <= twg_pkg::PeriodReset;
      tick_q      <= '0;
      pos_q       <= '0;
      up_quo_q    <= '0;
      up_rem_q    <= '0;
      dn_quo_q    <= TW'(8190);
      dn_rem_q    <= '0;
      sine_quo_q  <= '0;
      sine_rem_q  <= '0;
      lk_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          twg_pkg::CfgShape:  shape_q  <= cfg_data_i[1:0];
          twg_pkg::CfgGain:   gain_q   <= cfg_data_i[twg_pkg::GainW-1:0];
          twg_pkg::CfgPeriod: period_q <= cfg_data_i[twg_pkg::PeriodW-1:0];
          default: ;
        endcase
      end
      tick_q      <= tick_d;
      pos_q       <= pos_d;
      up_quo_q    <= up_quo_d;
      up_rem_q    <= up_rem_d;
      dn_quo_q    <= dn_quo_d;
      dn_rem_q    <= dn_rem_d;
      sine_quo_q  <= sine_quo_d;
      sine_rem_q  <= sine_rem_d;
      lk_valid_q  <= lk_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      lk_base_q  <= base;
      lk_index_q <= twg_pkg::IndexW'(pos_q);
      lk_end_q   <= (pos_q == LastPos);
    end
    if (out_load) begin
      out_code_q  <= code;
      out_index_q <= lk_index_q;
      out_end_q   <= lk_end_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign dac_code_o    = out_code_q;
  assign phase_index_o = out_index_q;
  assign cycle_end_o   = out_end_q;

  // The running quotients restart together with the table position.
  a_pos_zero_quotients: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_q == '0) |-> (up_quo_q == '0 && up_rem_q == '0 && sine_quo_q == '0
                       && sine_rem_q == '0 && dn_quo_q == TW'(8190)))
    else $error("table quotients out of step with position");

  // A tick that emits restarts the counter.
  a_emit_clears_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> (tick_q == '0))
    else $error("tick counter not cleared after a sample");

  // A sample held in the lookup stage is never dropped while the output stalls.
  a_lookup_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lk_valid_q && out_valid_q && !out_ready_i) |=> (lk_valid_q && out_valid_q))
    else $error("sample lost during output stall");

  // An emitting tick is only accepted while the lookup stage has room.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> (!lk_valid_q || out_load))
    else $error("lookup stage overwritten");

endmodule

`default_nettype wire

// ----- bench/tb_table_waveform_generator_top.sv -----
`timescale 1ns / 1ps

// Each input beat is one timer tick. Run beats step a tick counter, and a
// counter wrap emits one DAC sample. This bench keeps its own model of the
// counter, the table position and the three registers. Every accepted run beat
// is stepped through that model, and each sample it predicts (or the typed
// sample of a checked beat) is queued. The output monitor compares every
// accepted output beat with the oldest queued sample.
module tb_table_waveform_generator_top;

  localparam int unsigned Depth       = 256;
  localparam int unsigned FullCode    = twg_pkg::FullScale;
  localparam int unsigned DrainCycles = 8;      // Two pipeline stages plus margin.
  localparam int unsigned RandItems   = 450;
  localparam int unsigned PressBeats  = 200;
  localparam int unsigned HoldCycles  = 300;

  // The shape code that has no waveform, and a register index that the block
  // does not decode.
  localparam logic [1:0]                  ShapeFlat = 2'd3;
  localparam logic [twg_pkg::CfgIdxW-1:0] CfgNone   = 2'd3;

  typedef struct packed {
    logic [twg_pkg::CodeW-1:0]  code;
    logic [twg_pkg::IndexW-1:0] index;
    logic                       last;
  } dac_sample_t;

  localparam dac_sample_t NoSample = '{code: '0, index: '0, last: 1'b0};

  typedef enum logic {RowTick, RowCfg} row_kind_e;

  typedef enum int unsigned {ReadyAlways, ReadyCoin, ReadySparse, ReadyBlocks} ready_mode_e;

  // One row of the directed table. A tick row sends a number of beats with the
  // same run value. When the row is checked, its typed sample is the one
  // expected from its last beat.
  typedef struct {
    row_kind_e                      kind;
    logic [twg_pkg::CfgIdxW-1:0]    reg_index;
    logic [twg_pkg::CfgDataW-1:0]   reg_data;
    logic                           run;
    int unsigned                    beats;
    logic                           checked;
    dac_sample_t                    typed;
  } plan_row_t;

  // Quarter of a sine period, round(2047.5 * (1 + sin(2*pi*k/256))) for k = 0..64.
  int unsigned quarter_wave [0:64] = '{
    2048, 2098, 2148, 2198, 2248, 2298, 2348, 2398,
    2447, 2496, 2545, 2594, 2642, 2690, 2737, 2784,
    2831, 2877, 2923, 2968, 3013, 3057, 3100, 3143,
    3185, 3226, 3267, 3307, 3346, 3385, 3423, 3459,
    3495, 3530, 3565, 3598, 3630, 3662, 3692, 3722,
    3750, 3777, 3804, 3829, 3853, 3876, 3898, 3919,
    3939, 3958, 3975, 3992, 4007, 4021, 4034, 4045,
    4056, 4065, 4073, 4080, 4085, 4089, 4093, 4094,
    4095
  };

  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          in_valid_i  = 1'b0;
  logic                          run_i       = 1'b0;
  logic                          out_ready_i = 1'b0;
  logic                          cfg_valid_i = 1'b0;
  logic [twg_pkg::CfgIdxW-1:0]   cfg_index_i = '0;
  logic [twg_pkg::CfgDataW-1:0]  cfg_data_i  = '0;
  logic                          in_ready_o;
  logic                          out_valid_o;
  logic [twg_pkg::CodeW-1:0]     dac_code_o;
  logic [twg_pkg::IndexW-1:0]    phase_index_o;
  logic                          cycle_end_o;
  logic                          cfg_ready_o;

  // Model state: the registers as the block should hold them, the tick
  // counter and the table position.
  logic [1:0]                    m_shape  = twg_pkg::ShapeSine;
  logic [twg_pkg::GainW-1:0]     m_gain   = twg_pkg::GainReset;
  logic [twg_pkg::PeriodW-1:0]   m_period = twg_pkg::PeriodReset;
  logic [twg_pkg::PeriodW-1:0]   m_tick   = '0;
  int unsigned                   m_phase  = 0;

  dac_sample_t pending_samples [$];
  plan_row_t   directed_rows [$];
  int unsigned error_count = 0;
  int unsigned hold_reqs   = 0;

  table_waveform_generator_top #(
    .TABLE_DEPTH(Depth)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .run_i        (run_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .dac_code_o   (dac_code_o),
    .phase_index_o(phase_index_o),
    .cycle_end_o  (cycle_end_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Base value of the selected shape at a table position, before the gain.
  function automatic int unsigned shape_level(input logic [1:0] shape, input int unsigned pos);
    int unsigned j;
    j = ((pos * 256) / Depth) % 256;
    case (shape)
      twg_pkg::ShapeSine: begin
        // The quarter table is mirrored in time for the second quarter and
        // in value for the second half.
        if (j <= 64) return quarter_wave[j];
        if (j <= 128) return quarter_wave[128 - j];
        if (j < 192) return FullCode - quarter_wave[j - 128];
        return FullCode - quarter_wave[256 - j];
      end
      twg_pkg::ShapeTriangle: begin
        if (pos < Depth / 2) return (2 * FullCode * pos) / Depth;
        return (2 * FullCode * (Depth - pos)) / Depth;
      end
      twg_pkg::ShapeSquare: return (pos < Depth / 2) ? 0 : FullCode;
      default: return 0;
    endcase
  endfunction

  // Steps the model by one accepted tick beat. Returns 1 when the tick wraps
  // the counter, with the sample it emits in s.
  function automatic logic predict_tick(input logic run, output dac_sample_t s);
    int unsigned pos;
    int unsigned level;
    s = NoSample;
    if (!run) return 1'b0;
    // A period written below the running count also lands here, so the next
    // counted tick wraps at once.
    if (m_tick < m_period) begin
      m_tick = m_tick + 1'b1;
      return 1'b0;
    end
    m_tick = '0;
    pos    = m_phase;
    // The Q1.14 product is truncated by the shift and then clamped.
    level  = (shape_level(m_shape, pos) * m_gain) >> twg_pkg::GainShift;
    if (level > FullCode) level = FullCode;
    s.code  = level[twg_pkg::CodeW-1:0];
    s.index = pos[twg_pkg::IndexW-1:0];
    s.last  = (pos == Depth - 1);
    m_phase = (pos + 1 >= Depth) ? 0 : pos + 1;
    return 1'b1;
  endfunction

  // Offers one tick beat and holds it until accepted. A checked beat queues
  // its typed sample; any other beat queues what the model predicts.
  task automatic send_tick(input logic run, input logic checked, input dac_sample_t typed);
    dac_sample_t s;
    logic        fired;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    run_i      <= run;
    do @(posedge clk_i); while (!in_ready_o);
    fired = predict_tick(run, s);
    if (checked) pending_samples.push_back(typed);
    else if (fired) pending_samples.push_back(s);
  endtask

  // Register write; the model takes the new value on the accepted beat.
  // Bits above a register's width are dropped, and an unknown index is
  // ignored.
  task automatic write_reg(input logic [twg_pkg::CfgIdxW-1:0] idx,
                           input logic [twg_pkg::CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      twg_pkg::CfgShape:  m_shape  = data[1:0];
      twg_pkg::CfgGain:   m_gain   = data[twg_pkg::GainW-1:0];
      twg_pkg::CfgPeriod: m_period = data[twg_pkg::PeriodW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Stops offering ticks and waits until the block has delivered every
  // sample owed. Then it waits out the pipeline.
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic cfg_row(input logic [twg_pkg::CfgIdxW-1:0] idx,
                         input logic [twg_pkg::CfgDataW-1:0] data);
    directed_rows.push_back('{RowCfg, idx, data, 1'b0, 0, 1'b0, NoSample});
  endtask

  task automatic tick_row(input logic run, input int unsigned beats);
    directed_rows.push_back('{RowTick, CfgNone, '0, run, beats, 1'b0, NoSample});
  endtask

  task automatic checked_row(input int unsigned beats, input int unsigned code,
                             input int unsigned index, input logic last);
    dac_sample_t s;
    s.code  = code[twg_pkg::CodeW-1:0];
    s.index = index[twg_pkg::IndexW-1:0];
    s.last  = last;
    directed_rows.push_back('{RowTick, CfgNone, '0, 1'b1, beats, 1'b1, s});
  endtask

  // Picks new settings for one random phase. Each register is written with
  // some probability, so the old values, and the old count, sometimes carry
  // over into the next phase.
  task automatic shuffle_config();
    logic [twg_pkg::CfgDataW-1:0] d;
    if ($urandom_range(0, 3) != 0) begin
      d = $urandom_range(0, 1) ? twg_pkg::CfgDataW'($urandom)
                               : twg_pkg::CfgDataW'($urandom_range(0, 3));
      write_reg(twg_pkg::CfgShape, d);
    end
    if ($urandom_range(0, 3) != 0) begin
      case ($urandom_range(0, 5))
        0: d = '0;
        1: d = 16'h7FFF;
        2: d = twg_pkg::CfgDataW'($urandom);
        3: d = twg_pkg::CfgDataW'(twg_pkg::GainReset);
        default: d = twg_pkg::CfgDataW'($urandom_range(0, 24000));
      endcase
      write_reg(twg_pkg::CfgGain, d);
    end
    if ($urandom_range(0, 3) != 0) begin
      // Short periods keep samples frequent; long ones are rare.
      case ($urandom_range(0, 9))
        6, 7: d = twg_pkg::CfgDataW'($urandom_range(8, 40));
        8: d = '0;
        9: d = twg_pkg::CfgDataW'($urandom_range(41, 400));
        default: d = twg_pkg::CfgDataW'($urandom_range(0, 7));
      endcase
      write_reg(twg_pkg::CfgPeriod, d);
    end
    if ($urandom_range(0, 5) == 0) write_reg(CfgNone, twg_pkg::CfgDataW'($urandom));
  endtask

  // The output monitor. A beat is taken on a rising edge with valid and ready
  // both high, and it must match the oldest queued sample field by field.
  always @(posedge clk_i) begin : check_output
    dac_sample_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_samples.size() == 0) begin
        $error("unexpected sample beat: dac_code %0d phase_index %0d cycle_end %0b",
               dac_code_o, phase_index_o, cycle_end_o);
        error_count++;
      end else begin
        want = pending_samples.pop_front();
        if (dac_code_o !== want.code) begin
          $error("dac_code: expected %0d, got %0d", want.code, dac_code_o);
          error_count++;
        end
        if (phase_index_o !== want.index) begin
          $error("phase_index: expected %0d, got %0d", want.index, phase_index_o);
          error_count++;
        end
        if (cycle_end_o !== want.last) begin
          $error("cycle_end: expected %0b, got %0b", want.last, cycle_end_o);
          error_count++;
        end
      end
    end
  end

  // The receiver picks a new stall pattern after each random span. When the
  // stimulus asks for a hold-off, it refuses every output beat for a long,
  // counted stretch, so the block fills up and has to stall its input.
  initial begin : receiver
    ready_mode_e mode;
    int unsigned span;
    int unsigned hold_left;
    int unsigned served;
    mode      = ReadyAlways;
    span      = 0;
    hold_left = 0;
    served    = 0;
    forever begin
      @(negedge clk_i);
      if (hold_left == 0 && served != hold_reqs) begin
        hold_left = HoldCycles;
        served++;
      end
      if (span == 0) begin
        mode = ready_mode_e'($urandom_range(0, 3));
        span = $urandom_range(16, 128);
      end
      span--;
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        case (mode)
          ReadyAlways: out_ready_i <= 1'b1;
          ReadyCoin:   out_ready_i <= 1'($urandom_range(0, 1));
          ReadySparse: out_ready_i <= ($urandom_range(0, 3) == 0);
          default:     out_ready_i <= span[2];
        endcase
      end
    end
  end

  initial begin : stimulus
    int unsigned sent;
    int unsigned count;
    int unsigned burst;
    int unsigned gap;
    logic        steady;
    logic        pressed;
    logic        run;

    sent    = 0;
    burst   = 0;
    pressed = 1'b0;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed table. It starts with the reset settings (sine, unity gain,
    // period 1098), so the first sample needs 1099 counted ticks and comes
    // from the first sine table entry, at mid-scale.
    checked_row(1099, 2048, 0, 1'b0);
    tick_row(1'b0, 3);                        // Run low holds the counter and position.
    cfg_row(twg_pkg::CfgPeriod, 16'd0);       // Period zero: a sample on every run beat.
    tick_row(1'b1, 1);
    cfg_row(twg_pkg::CfgGain, 16'd0);         // Zero gain silences the output.
    checked_row(1, 0, 2, 1'b0);
    cfg_row(twg_pkg::CfgGain, 16'hFFFF);      // Top bit dropped: largest gain, clamps.
    checked_row(1, 4095, 3, 1'b0);
    // The unused shape code gives a flat zero.
    cfg_row(twg_pkg::CfgShape, twg_pkg::CfgDataW'(ShapeFlat));
    checked_row(1, 0, 4, 1'b0);
    cfg_row(twg_pkg::CfgShape, 16'hFFFD);     // Upper bits dropped: triangle.
    tick_row(1'b1, 4);
    cfg_row(twg_pkg::CfgShape, twg_pkg::CfgDataW'(twg_pkg::ShapeSquare));
    cfg_row(twg_pkg::CfgGain, twg_pkg::CfgDataW'(twg_pkg::GainReset));
    tick_row(1'b1, 2);
    cfg_row(CfgNone, 16'h1234);               // Unknown index must change nothing.
    tick_row(1'b1, 1);
    checked_row(244, 4095, 255, 1'b1);        // Last table entry closes the period.
    checked_row(1, 0, 0, 1'b0);               // Position wraps to the first entry.
    cfg_row(twg_pkg::CfgPeriod, 16'd40);
    tick_row(1'b1, 10);
    tick_row(1'b0, 2);
    cfg_row(twg_pkg::CfgPeriod, 16'd3);       // Now below the count: wraps at once.
    tick_row(1'b1, 6);
    cfg_row(twg_pkg::CfgShape, twg_pkg::CfgDataW'(twg_pkg::ShapeSine));
    cfg_row(twg_pkg::CfgPeriod, 16'hFFFF);    // Longest period; the count keeps climbing.
    tick_row(1'b1, 8);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == RowCfg) begin
        settle();
        write_reg(directed_rows[i].reg_index, directed_rows[i].reg_data);
      end else begin
        for (int n = 1; n <= directed_rows[i].beats; n++) begin
          send_tick(directed_rows[i].run, directed_rows[i].checked && n == directed_rows[i].beats,
                    directed_rows[i].typed);
        end
      end
    end

    // Random phases, with new settings between them. Only run beats count
    // toward the total, since beats with run low only hold the state.
    while (sent < RandItems) begin
      settle();
      shuffle_config();
      if (!pressed && sent >= RandItems / 2) begin
        // Back-pressure phase: each beat emits, and the receiver refuses every
        // output beat for a long stretch while beats keep coming.
        write_reg(twg_pkg::CfgPeriod, 16'd0);
        hold_reqs++;
        repeat (PressBeats) send_tick(1'b1, 1'b0, NoSample);
        sent    += PressBeats;
        pressed  = 1'b1;
      end else begin
        count  = $urandom_range(30, 140);
        steady = ($urandom_range(0, 3) == 0);
        repeat (count) begin
          if (burst == 0) begin
            burst = $urandom_range(1, 24);
            gap   = steady ? 0 : $urandom_range(0, 6);
            if (gap != 0) begin
              @(negedge clk_i);
              in_valid_i <= 1'b0;
              repeat (gap - 1) @(negedge clk_i);
            end
          end
          burst--;
          run = ($urandom_range(0, 7) != 0);
          send_tick(run, 1'b0, NoSample);
          if (run) sent++;
        end
      end
    end

    settle();
    if (error_count == 0) begin
      $display("tb_table_waveform_generator_top OK");
    end else begin
      $display("tb_table_waveform_generator_top NOT OK");
    end
    $finish;
  end

  // Watchdog. The slowest correct run is well under a millisecond of
  // simulated time.
  initial begin : watchdog
    #5_000_000;
    $display("tb_table_waveform_generator_top NOT OK");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/twg_pkg.sv
sv/twg_base.sv
sv/table_waveform_generator_top.sv
bench/tb_table_waveform_generator_top.sv
